// File: sv/itda_pkg.sv
`default_nettype none

package itda_pkg;

  localparam int unsigned ValueW        = 32;
  localparam int unsigned CapW          = 8;
  localparam int unsigned CharW         = 8;
  localparam int unsigned LenW          = 4;
  localparam int unsigned NumDigits     = 10;
  localparam int unsigned DigitIdxW     = 4;
  localparam int unsigned StageBits     = 8;
  localparam int unsigned NumConvStages = ValueW / StageBits;

  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharMinus = 8'h2D;
  localparam logic [CharW-1:0] CharNul   = 8'h00;

  typedef logic [NumDigits-1:0][3:0] digits_t;

  // Payload of the binary-to-BCD stages.
  typedef struct packed {
    logic [ValueW-1:0] mag;
    digits_t           bcd;
    logic              neg;
    logic [CapW-1:0]   capacity;
  } conv_t;

  // Payload handed to the serializer.
  typedef struct packed {
    digits_t              digits;
    logic [DigitIdxW-1:0] top_idx;
    logic                 neg;
    logic [LenW-1:0]      keep;
    logic                 zero_cap;
  } prep_t;

  // One shift-and-add-3 step: adjust every digit, then shift one bit in.
  function automatic conv_t dabble_step(conv_t c);
    conv_t   r;
    digits_t adj;
    r = c;
    for (int k = 0; k < NumDigits; k++) begin
      adj[k] = (c.bcd[k] >= 4'd5) ? c.bcd[k] + 4'd3 : c.bcd[k];
    end
    {r.bcd, r.mag} = {adj, c.mag} << 1;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/itda_if.sv
`default_nettype none

interface itda_in_if;
  import itda_pkg::*;
  logic              valid;
  logic              ready;
  logic              command;
  logic [ValueW-1:0] value;
  logic [CapW-1:0]   capacity;

  modport source (output valid, command, value, capacity, input ready);
  modport sink   (input valid, command, value, capacity, output ready);
endinterface

interface itda_out_if;
  import itda_pkg::*;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] character;
  logic             written;
  logic             last;
  logic [LenW-1:0]  length;

  modport source (output valid, character, written, last, length, input ready);
  modport sink   (input valid, character, written, last, length, output ready);
endinterface

`default_nettype wire

// File: sv/itda_conv_stage.sv
`default_nettype none

module itda_conv_stage
  import itda_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  input  wire conv_t data_i,
  output logic       ready_o,
  output logic       valid_o,
  output conv_t      data_o,
  input  wire logic  ready_i
);

  logic  valid_q;
  conv_t data_q, data_d;

  // Eight dependent shift-and-add-3 steps per stage.
  always_comb begin
    data_d = data_i;
    for (int s = 0; s < StageBits; s++) begin
      data_d = dabble_step(data_d);
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// File: sv/itda_prep.sv
`default_nettype none

module itda_prep
  import itda_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  input  wire conv_t data_i,
  output logic       ready_o,
  output logic       valid_o,
  output prep_t      data_o,
  input  wire logic  ready_i
);

  logic                 valid_q;
  prep_t                data_q, data_d;
  logic [DigitIdxW-1:0] top;
  logic [LenW-1:0]      text_len;

  // The most significant nonzero digit sets the digit count; zero has one digit.
  always_comb begin
    top = '0;
    for (int k = 1; k < NumDigits; k++) begin
      if (data_i.bcd[k] != 4'd0) begin
        top = DigitIdxW'(k);
      end
    end
    text_len = LenW'(top) + LenW'(1) + LenW'(data_i.neg);

    data_d.digits   = data_i.bcd;
    data_d.top_idx  = top;
    data_d.neg      = data_i.neg;
    data_d.zero_cap = (data_i.capacity == '0);
    if (data_i.capacity == '0) begin
      data_d.keep = '0;
    end else if ({4'd0, text_len} >= data_i.capacity) begin
      data_d.keep = LenW'(data_i.capacity - CapW'(1));
    end else begin
      data_d.keep = text_len;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// File: sv/itda_serializer.sv
`default_nettype none

module itda_serializer
  import itda_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         valid_i,
  input  wire prep_t        data_i,
  output logic              ready_o,
  itda_out_if.source        out_o
);

  logic                 busy_q;
  logic                 neg_q;
  logic                 zero_cap_q;
  logic [DigitIdxW-1:0] ptr_q;
  logic [LenW-1:0]      rem_q;
  logic [LenW-1:0]      keep_q;
  digits_t              digits_q;

  logic                 out_valid_q;
  logic [CharW-1:0]     char_q;
  logic                 written_q;
  logic                 last_q;
  logic [LenW-1:0]      length_q;

  logic out_adv, emit, finish, load;

  assign out_adv = !out_valid_q || out_o.ready;
  assign emit    = busy_q && out_adv;
  assign finish  = emit && (rem_q == '0);
  assign ready_o = !busy_q || finish;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_adv) begin
        out_valid_q <= busy_q;
      end
      if (load) begin
        busy_q <= 1'b1;
      end else if (finish) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      if (rem_q != '0) begin
        char_q    <= neg_q ? CharMinus : CharZero + {4'd0, digits_q[ptr_q]};
        written_q <= 1'b1;
        last_q    <= 1'b0;
        length_q  <= '0;
        rem_q     <= rem_q - LenW'(1);
        if (neg_q) begin
          neg_q <= 1'b0;
        end else begin
          ptr_q <= ptr_q - DigitIdxW'(1);
        end
      end else begin
        char_q    <= CharNul;
        written_q <= !zero_cap_q;
        last_q    <= 1'b1;
        length_q  <= keep_q;
      end
    end
    if (load) begin
      digits_q   <= data_i.digits;
      ptr_q      <= data_i.top_idx;
      neg_q      <= data_i.neg;
      rem_q      <= data_i.keep;
      keep_q     <= data_i.keep;
      zero_cap_q <= data_i.zero_cap;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.character = char_q;
  assign out_o.written   = written_q;
  assign out_o.last      = last_q;
  assign out_o.length    = length_q;

endmodule

`default_nettype wire

// File: sv/int_to_decimal_ascii_core.sv
// Decimal text generator for 32-bit integers.
//
// Input channel in_i carries one beat per value: command (0 unsigned,
// 1 two's complement signed), the 32-bit value and the buffer capacity in
// bytes, terminator included. Output channel out_o gives one beat per
// character, most significant digit first, with a leading '-' for negative
// signed values, cut to capacity-1 characters, then a terminator beat
// (character 0, last 1) carrying the written length. Capacity zero gives a
// single terminator beat with written 0.
//
// Pipeline: the sign stage captures a value as it is taken; then four
// binary-to-BCD stages of eight bits each, the digit count stage, the
// serializer load and the output register pass it on in turn, each through a
// register. A value gives keep+1 beats, between 1 and 12, one beat per cycle
// while the receiver is ready; the front stages take a new value every cycle
// unless stalled, and queue up to six of them.
//
// Reset clears all valid bits; no beat is presented afterwards until a value
// arrives. When the receiver holds ready low, the output beat holds, the
// serializer waits, and the front stages fill and then drop in_i.ready.
`default_nettype none

module int_to_decimal_ascii_core
  import itda_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  itda_in_if.sink    in_i,
  itda_out_if.source out_o
);

  // Sign stage: negative signed values are replaced by their magnitude.
  // The most negative value maps onto itself, read as unsigned.
  logic  s0_valid_q;
  conv_t s0_data_q;
  logic  s0_ready;
  logic  in_neg;

  conv_t cv_data  [NumConvStages+1];
  logic  cv_valid [NumConvStages+1];
  logic  cv_ready [NumConvStages+1];

  logic  prep_valid, prep_ready;
  prep_t prep_data;

  assign in_neg     = in_i.command && in_i.value[ValueW-1];
  assign s0_ready   = !s0_valid_q || cv_ready[0];
  assign in_i.ready = s0_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (s0_ready) begin
      s0_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_ready && in_i.valid) begin
      s0_data_q.mag      <= in_neg ? ValueW'(0) - in_i.value : in_i.value;
      s0_data_q.bcd      <= '0;
      s0_data_q.neg      <= in_neg;
      s0_data_q.capacity <= in_i.capacity;
    end
  end

  assign cv_data[0]  = s0_data_q;
  assign cv_valid[0] = s0_valid_q;

  // Binary-to-BCD conversion, eight value bits per stage.
  for (genvar g = 0; g < NumConvStages; g++) begin : g_conv
    itda_conv_stage u_conv (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv_valid[g]),
      .data_i  (cv_data[g]),
      .ready_o (cv_ready[g]),
      .valid_o (cv_valid[g+1]),
      .data_o  (cv_data[g+1]),
      .ready_i (cv_ready[g+1])
    );
  end

  // Digit count and truncation length.
  itda_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cv_valid[NumConvStages]),
    .data_i  (cv_data[NumConvStages]),
    .ready_o (cv_ready[NumConvStages]),
    .valid_o (prep_valid),
    .data_o  (prep_data),
    .ready_i (prep_ready)
  );

  // One character per cycle into the output register while the receiver is ready.
  itda_serializer u_ser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_valid),
    .data_i  (prep_data),
    .ready_o (prep_ready),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

// File: sv/itda_checker.sv
`default_nettype none

module itda_checker
  import itda_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             out_valid_i,
  input wire logic             out_ready_i,
  input wire logic [CharW-1:0] out_character_i,
  input wire logic             out_written_i,
  input wire logic             out_last_i,
  input wire logic [LenW-1:0]  out_length_i
);

  // A stalled beat stays presented.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output beat dropped while stalled");

  // Text beats carry a digit or a minus sign, are stored and have no length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |->
      out_written_i && out_length_i == '0 &&
      ((out_character_i >= CharZero && out_character_i <= CharZero + CharW'(9)) ||
       out_character_i == CharMinus))
    else $error("malformed text beat");

  // The terminator is a zero byte with a length of at most eleven.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_last_i |->
      out_character_i == CharNul && out_length_i <= LenW'(11))
    else $error("malformed terminator beat");

  // An unwritten terminator is the lone beat of a run, so it has length zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_written_i |-> out_last_i && out_length_i == '0)
    else $error("unwritten beat with nonzero length");

endmodule

bind int_to_decimal_ascii_core itda_checker u_itda_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_character_i (out_o.character),
  .out_written_i   (out_o.written),
  .out_last_i      (out_o.last),
  .out_length_i    (out_o.length)
);

`default_nettype wire
